// ===== src/msbt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msbt_pkg
// Shared types and codes for the multiset bag table: action and status codes,
// controller states, and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package msbt_pkg;

	localparam int IN_BYTES_W  = 40;
	localparam int OUT_BYTES_W = 48;

	typedef logic [2:0] action_t;
	localparam action_t ACT_INSERT    = 3'd0;
	localparam action_t ACT_COUNT     = 3'd1;
	localparam action_t ACT_ERASE_ONE = 3'd2;
	localparam action_t ACT_ERASE_ALL = 3'd3;
	localparam action_t ACT_READ      = 3'd4;

	typedef logic [1:0] status_code_t;
	localparam status_code_t ST_OK       = 2'd0;
	localparam status_code_t ST_FULL     = 2'd1;
	localparam status_code_t ST_NO_MATCH = 2'd2;
	localparam status_code_t ST_RANGE    = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_WALK,
		S_RDWAIT,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic ins;
		logic issue;
		logic proc;
		logic rd_pos;
		logic grab;
		logic finish;
	} cmd_t;

	typedef struct packed {
		action_t act;
		logic    more;
		logic    dv;
		logic    pos_ok;
		logic    out_busy;
	} dp_status_t;

endpackage

// ===== src/msbt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msbt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module msbt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/msbt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msbt_ctrl
// Controller state machine: accepts a transaction, sequences the entry walk
// or single access, and releases the result to the output register.
// ----------------------------------------------------------------------------
module msbt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  msbt_pkg::dp_status_t st,
	output msbt_pkg::cmd_t      cmd
);

	import msbt_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				case (st.act)
					ACT_INSERT: begin
						cmd.ins = 1'b1;
						state_d = S_FINISH;
					end
					ACT_COUNT, ACT_ERASE_ONE, ACT_ERASE_ALL: begin
						state_d = S_WALK;
					end
					ACT_READ: begin
						if (st.pos_ok) begin
							cmd.rd_pos = 1'b1;
							state_d    = S_RDWAIT;
						end else begin
							state_d = S_FINISH;
						end
					end
					default: begin
						state_d = S_FINISH;
					end
				endcase
			end
			S_WALK: begin
				cmd.issue = st.more;
				cmd.proc  = st.dv;
				if (!st.more && !st.dv) begin
					state_d = S_FINISH;
				end
			end
			S_RDWAIT: begin
				cmd.grab = 1'b1;
				state_d  = S_FINISH;
			end
			S_FINISH: begin
				if (!st.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== src/msbt_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msbt_dp
// Datapath: operand registers, walk counters, entry RAM, fill count and the
// result output register.
// ----------------------------------------------------------------------------
module msbt_dp #(
	parameter int CAPACITY    = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  msbt_pkg::cmd_t                      cmd,
	output msbt_pkg::dp_status_t                st,
	input  logic [msbt_pkg::IN_BYTES_W-1:0]     in_data,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [msbt_pkg::OUT_BYTES_W-1:0]    out_data
);

	import msbt_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 4) ? CW : 4;

	action_t          act_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [3:0]       pos_q;
	logic [CW-1:0]    ri_q, wi_q, tally_q, cnt_q;
	logic             removed_q, dv_q;
	logic [VALUE_WIDTH-1:0] rd_q;
	logic             mv_q;
	logic [OUT_BYTES_W-1:0] md_q;

	logic             full, match, drop, we;
	logic [AW-1:0]    waddr, raddr;
	logic [VALUE_WIDTH-1:0] wdata, ram_rdata;
	status_code_t     res_status;
	logic [CW-1:0]    res_tally, cnt_d;

	assign full  = (cnt_q == CW'(CAPACITY));
	assign match = (ram_rdata == val_q);
	assign drop  = match && ((act_q != ACT_ERASE_ONE) || !removed_q);

	assign we    = (cmd.ins && !full) || (cmd.proc && !drop && (act_q != ACT_COUNT));
	assign waddr = cmd.ins ? cnt_q[AW-1:0] : wi_q[AW-1:0];
	assign wdata = cmd.ins ? val_q : ram_rdata;
	assign raddr = cmd.rd_pos ? AW'(pos_q) : ri_q[AW-1:0];

	msbt_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		st.act      = act_q;
		st.more     = (ri_q < cnt_q);
		st.dv       = dv_q;
		st.pos_ok   = (PW'(pos_q) < PW'(cnt_q));
		st.out_busy = mv_q && !out_ready;
	end

	always_comb begin
		res_status = ST_OK;
		res_tally  = '0;
		cnt_d      = cnt_q;
		case (act_q)
			ACT_INSERT: begin
				if (full) begin
					res_status = ST_FULL;
				end else begin
					cnt_d = cnt_q + CW'(1);
				end
			end
			ACT_COUNT: begin
				res_tally = tally_q;
			end
			ACT_ERASE_ONE: begin
				cnt_d = wi_q;
				if (!removed_q) begin
					res_status = ST_NO_MATCH;
				end
			end
			ACT_ERASE_ALL: begin
				cnt_d     = wi_q;
				res_tally = tally_q;
			end
			ACT_READ: begin
				if (!st.pos_ok) begin
					res_status = ST_RANGE;
				end
			end
			default: begin
				res_status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= in_data[2:0];
			val_q <= VALUE_WIDTH'(in_data[34:3]);
			pos_q <= in_data[38:35];
			rd_q  <= '0;
		end else if (cmd.grab) begin
			rd_q <= ram_rdata;
		end
		if (cmd.finish) begin
			md_q <= {4'b0, 5'(cnt_d), 32'(rd_q), 5'(res_tally), res_status};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ri_q      <= '0;
			wi_q      <= '0;
			tally_q   <= '0;
			removed_q <= 1'b0;
			dv_q      <= 1'b0;
			cnt_q     <= '0;
			mv_q      <= 1'b0;
		end else begin
			dv_q <= cmd.issue;
			if (cmd.load) begin
				ri_q      <= '0;
				wi_q      <= '0;
				tally_q   <= '0;
				removed_q <= 1'b0;
			end else begin
				if (cmd.issue) begin
					ri_q <= ri_q + CW'(1);
				end
				if (cmd.proc) begin
					if (drop) begin
						tally_q   <= tally_q + CW'(1);
						removed_q <= 1'b1;
					end else begin
						wi_q <= wi_q + CW'(1);
					end
				end
			end
			if (cmd.finish) begin
				cnt_q <= cnt_d;
				mv_q  <= 1'b1;
			end else if (out_ready) begin
				mv_q <= 1'b0;
			end
		end
	end

	assign out_valid = mv_q;
	assign out_data  = md_q;

endmodule

// ===== src/multiset_bag_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiset_bag_table_top
// Fixed-capacity, order-keeping multiset of signed values with insert, count,
// erase-one, erase-all and positional read.
// ----------------------------------------------------------------------------
// Usage:
// Each transaction on the s_axis channel carries one action; the block
// returns exactly one result transaction on the m_axis channel.
// Insert and the unused action codes go from decode straight to the finish
// step; read passes through a read-wait state when its position is in range.
// Count, erase-one and erase-all walk every held entry through the entry RAM
// read port, one entry per cycle, and then go to the finish step. Erase
// shifts survivors down through the RAM write port in the same walk.
// One action is processed at a time. The next transaction is accepted in the
// cycle after the result is registered. The result sits in an output
// register, so the next transaction is accepted while the previous result
// still waits; a stalled receiver holds only the finish step of the
// following action. Asynchronous reset empties the table (fill count zero)
// and drops any pending result; the RAM contents are not cleared.
// ----------------------------------------------------------------------------
module multiset_bag_table_top #(
	parameter int CAPACITY    = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [2:0] action, [34:3] value, [38:35] position, [39] zero
	input  logic [39:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [1:0] status, [6:2] tally, [38:7] read_value, [43:39] fill_count, [47:44] zero
	output logic [47:0] m_axis_tdata
);

	import msbt_pkg::*;

	cmd_t       cmd;
	dp_status_t st;

	msbt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.st      (st),
		.cmd     (cmd)
	);

	msbt_dp #(
		.CAPACITY   (CAPACITY),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.in_data  (s_axis_tdata),
		.out_ready(m_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_data (m_axis_tdata)
	);

endmodule

// ===== bench/tb_multiset_bag_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multiset_bag_table_top
// Self-checking bench for the multiset bag table. A bursty driver feeds
// directed and phased random actions from a queue, and a shadow bag predicts
// each result when its transaction is accepted. A monitor compares every
// returned result field by field while the receiver stalls on its own
// pattern, including long hold-offs that back the block up.
// ----------------------------------------------------------------------------
module tb_multiset_bag_table_top;
	import msbt_pkg::*;

	localparam int BAG_CAP = 16;
	localparam action_t ACT_UNUSED_FIRST = 3'd5;
	localparam action_t ACT_UNUSED_LAST  = 3'd7;
	localparam int RANDOM_ITEMS = 1300;

	typedef struct packed {
		action_t     act;
		logic [31:0] value;
		logic [3:0]  pos;
	} bag_cmd_t;

	typedef struct packed {
		status_code_t status;
		logic [4:0]   tally;
		logic [31:0]  read_value;
		logic [4:0]   fill_count;
	} bag_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;

	bag_cmd_t    cmd_queue[$];
	bag_result_t expected_results[$];

	logic [31:0] bag_mem[BAG_CAP];
	int          bag_fill = 0;
	int          peak_fill = 0;
	int          act_seen[8];
	int          status_seen[4];
	int          results_checked = 0;
	int          mismatches = 0;
	logic [31:0] value_pool[8];

	multiset_bag_table_top #(
		.CAPACITY(BAG_CAP),
		.VALUE_WIDTH(32)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	function automatic bag_result_t apply_bag_action(bag_cmd_t c);
		bag_result_t r;
		int i;
		int j;
		int n;
		int hit;
		r = '0;
		n = 0;
		hit = -1;
		case (c.act)
			ACT_INSERT: begin
				if (bag_fill < BAG_CAP) begin
					bag_mem[bag_fill] = c.value;
					bag_fill++;
				end else begin
					r.status = ST_FULL;
				end
			end
			ACT_COUNT: begin
				for (i = 0; i < bag_fill; i++)
					if (bag_mem[i] == c.value)
						n++;
				r.tally = 5'(n);
			end
			ACT_ERASE_ONE: begin
				for (i = 0; i < bag_fill && hit < 0; i++)
					if (bag_mem[i] == c.value)
						hit = i;
				if (hit >= 0) begin
					for (i = hit; i + 1 < bag_fill; i++)
						bag_mem[i] = bag_mem[i + 1];
					bag_fill--;
				end else begin
					r.status = ST_NO_MATCH;
				end
			end
			ACT_ERASE_ALL: begin
				j = 0;
				for (i = 0; i < bag_fill; i++) begin
					if (bag_mem[i] == c.value) begin
						n++;
					end else begin
						bag_mem[j] = bag_mem[i];
						j++;
					end
				end
				bag_fill = j;
				r.tally = 5'(n);
			end
			ACT_READ: begin
				if (c.pos < bag_fill)
					r.read_value = bag_mem[c.pos];
				else
					r.status = ST_RANGE;
			end
			default: ;
		endcase
		r.fill_count = 5'(bag_fill);
		act_seen[c.act]++;
		status_seen[r.status]++;
		if (bag_fill > peak_fill)
			peak_fill = bag_fill;
		return r;
	endfunction

	task automatic note_mismatch(string what, longint want, longint got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch, expected %0d, got %0d",
				$realtime, what, want, got);
	endtask

	task automatic push_cmd(action_t act, logic [31:0] value, logic [3:0] pos);
		bag_cmd_t c;
		c.act = act;
		c.value = value;
		c.pos = pos;
		cmd_queue.push_back(c);
	endtask

	function automatic logic [31:0] pick_value();
		if ($urandom_range(0, 4) == 0)
			return $urandom;
		return value_pool[$urandom_range(0, 7)];
	endfunction

	// Phase 0 builds the bag up, phase 1 tears it down, phase 2 is a free mix.
	function automatic action_t pick_action(int phase);
		int w;
		w = $urandom_range(0, 99);
		case (phase)
			0: begin
				if (w < 70) return ACT_INSERT;
				if (w < 80) return ACT_COUNT;
				if (w < 92) return ACT_READ;
				if (w < 97) return ACT_ERASE_ONE;
				return ACT_ERASE_ALL;
			end
			1: begin
				if (w < 35) return ACT_ERASE_ONE;
				if (w < 55) return ACT_ERASE_ALL;
				if (w < 65) return ACT_COUNT;
				if (w < 80) return ACT_READ;
				if (w < 95) return ACT_INSERT;
				return action_t'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
			end
			default: begin
				if (w < 30) return ACT_INSERT;
				if (w < 45) return ACT_COUNT;
				if (w < 58) return ACT_ERASE_ONE;
				if (w < 68) return ACT_ERASE_ALL;
				if (w < 92) return ACT_READ;
				return action_t'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
			end
		endcase
	endfunction

	int gap_left = 0;
	int burst_left = 1;

	always @(posedge clk) begin
		bag_cmd_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (cmd_queue.size() > 0) begin
				nxt = cmd_queue.pop_front();
				s_axis_tdata <= {1'b0, nxt.pos, nxt.value, nxt.act};
				s_axis_tvalid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	int rx_cycle = 0;
	int hold_left = 0;
	int mode_left = 0;
	int rx_mode = 0;

	always @(posedge clk) begin
		logic rdy;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			rx_cycle++;
			if (rx_cycle == 1500 || rx_cycle == 15000)
				hold_left = 400;
			if (mode_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end else begin
				mode_left--;
			end
			case (rx_mode)
				0: rdy = 1'b1;
				1: rdy = 1'($urandom_range(0, 1));
				2: rdy = ($urandom_range(0, 3) == 0);
				default: rdy = (rx_cycle % 3 != 0);
			endcase
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end
			m_axis_tready <= rdy;
		end
	end

	// Results are checked before the new transaction is predicted, so an
	// expectation pushed at this edge can never be consumed at the same edge.
	always @(posedge clk) begin
		bag_result_t got;
		bag_result_t want;
		bag_cmd_t    c;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.status = m_axis_tdata[1:0];
				got.tally = m_axis_tdata[6:2];
				got.read_value = m_axis_tdata[38:7];
				got.fill_count = m_axis_tdata[43:39];
				results_checked++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result arrived with nothing outstanding", $realtime);
				end else begin
					want = expected_results.pop_front();
					if (got.status != want.status)
						note_mismatch("status", want.status, got.status);
					if (got.tally != want.tally)
						note_mismatch("tally", want.tally, got.tally);
					if (got.read_value != want.read_value)
						note_mismatch("read_value", $signed(want.read_value),
							$signed(got.read_value));
					if (got.fill_count != want.fill_count)
						note_mismatch("fill_count", want.fill_count, got.fill_count);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				c.act = s_axis_tdata[2:0];
				c.value = s_axis_tdata[34:3];
				c.pos = s_axis_tdata[38:35];
				expected_results.push_back(apply_bag_action(c));
			end
		end
	end

	initial begin
		#5000000;
		$display("FAIL");
		$finish;
	end

	initial begin
		int produced;
		int phase;
		int phase_len;
		int k;
		int unused_seen;
		action_t a;
		value_pool[0] = 32'h0000_0000;
		value_pool[1] = 32'hFFFF_FFFF;
		value_pool[2] = 32'h7FFF_FFFF;
		value_pool[3] = 32'h8000_0000;
		value_pool[4] = 32'd5;
		value_pool[5] = -32'sd5;
		value_pool[6] = 32'd1234;
		value_pool[7] = $urandom;

		// Empty bag corners, then the value extremes and every action.
		push_cmd(ACT_COUNT, 32'h0, 4'd0);
		push_cmd(ACT_ERASE_ONE, 32'h0, 4'd0);
		push_cmd(ACT_ERASE_ALL, 32'h0, 4'd0);
		push_cmd(ACT_READ, 32'h0, 4'd0);
		push_cmd(ACT_INSERT, 32'h8000_0000, 4'd0);
		push_cmd(ACT_INSERT, 32'h7FFF_FFFF, 4'd0);
		push_cmd(ACT_INSERT, 32'hFFFF_FFFF, 4'd0);
		push_cmd(ACT_INSERT, 32'h0, 4'd0);
		push_cmd(ACT_INSERT, 32'h7FFF_FFFF, 4'd0);
		push_cmd(ACT_COUNT, 32'h7FFF_FFFF, 4'd0);
		push_cmd(ACT_READ, 32'h0, 4'd1);
		push_cmd(ACT_READ, 32'h0, 4'd15);
		push_cmd(ACT_READ, 32'h0, 4'd5);
		push_cmd(ACT_ERASE_ONE, 32'h7FFF_FFFF, 4'd0);
		push_cmd(ACT_READ, 32'h0, 4'd1);
		push_cmd(ACT_ERASE_ALL, 32'hFFFF_FFFF, 4'd0);
		push_cmd(ACT_ERASE_ONE, 32'h1234_5678, 4'd0);
		for (k = ACT_UNUSED_FIRST; k <= ACT_UNUSED_LAST; k++)
			push_cmd(action_t'(k), $urandom, 4'd15);
		push_cmd(ACT_READ, 32'hFFFF_FFFF, 4'd0);

		// Phased random part; the first phase is long enough to fill the bag.
		produced = 0;
		phase = 0;
		phase_len = 40;
		while (produced < RANDOM_ITEMS) begin
			for (k = 0; k < phase_len && produced < RANDOM_ITEMS; k++) begin
				a = pick_action(phase);
				push_cmd(a, pick_value(),
					4'(($urandom_range(0, 1) == 0) ?
						$urandom_range(0, 7) : $urandom_range(0, 15)));
				produced++;
			end
			phase = $urandom_range(0, 2);
			phase_len = $urandom_range(20, 80);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_queue.size() > 0 || s_axis_tvalid)
			@(posedge clk);
		while (expected_results.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		unused_seen = 0;
		for (k = ACT_UNUSED_FIRST; k <= ACT_UNUSED_LAST; k++)
			unused_seen += act_seen[k];

		$display("Checked %0d results: %0d inserts, %0d counts, %0d erase-one,",
			results_checked, act_seen[ACT_INSERT], act_seen[ACT_COUNT],
			act_seen[ACT_ERASE_ONE]);
		$display("%0d erase-all, %0d reads, %0d unused codes; full %0d, no match %0d,",
			act_seen[ACT_ERASE_ALL], act_seen[ACT_READ], unused_seen,
			status_seen[ST_FULL], status_seen[ST_NO_MATCH]);
		$display("out of range %0d, peak fill %0d.", status_seen[ST_RANGE], peak_fill);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("Errors: %0d", mismatches);
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/msbt_pkg.sv
src/msbt_ram.sv
src/msbt_ctrl.sv
src/msbt_dp.sv
src/multiset_bag_table_top.sv
bench/tb_multiset_bag_table_top.sv
